FILE: sv/rlsd_pkg.sv
`timescale 1ns / 1ps
// Package for the reflective level sensor debounce block.
// Widths, function and register codes, phase type and the structs used by the modules.
// No dependencies.
package rlsd_pkg;

    localparam int SAMPLE_W   = 10;
    localparam int TICK_W     = 16;
    localparam int DEB_W      = 4;
    localparam int FUNC_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // item function codes
    localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CONV = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FILL = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLL     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIP     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEB_MAX  = 2'd3;

    localparam logic [TICK_W-1:0]   SETTLE_RST  = 16'd10;
    localparam logic [TICK_W-1:0]   POLL_RST    = 16'd250;
    localparam logic [SAMPLE_W-1:0] TRIP_RST    = 10'd405;
    localparam logic [DEB_W-1:0]    DEB_MAX_RST = 4'd8;

    typedef enum logic [1:0] {
        PH_LED_ON = 2'd0,
        PH_SETTLE = 2'd1,
        PH_WAIT   = 2'd2
    } t_phase;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [SAMPLE_W-1:0] sample;
        logic                fill_on;
    } t_item;

    typedef struct packed {
        logic                valid;
        logic [SAMPLE_W-1:0] sample;
    } t_eval;

    typedef struct packed {
        logic                led_on;
        logic                adc_start;
        logic                valve_pullup;
        logic [SAMPLE_W-1:0] signal_quality;
    } t_seq_stat;

    typedef struct packed {
        logic water_present;
        logic change_event;
    } t_deb_stat;

    typedef struct packed {
        logic                led_on;
        logic                adc_start;
        logic                valve_pullup;
        logic                water_present;
        logic                change_event;
        logic [SAMPLE_W-1:0] signal_quality;
    } t_result;

endpackage

FILE: sv/rlsd_in_if.sv
`timescale 1ns / 1ps
// Input channel interface: valid/ready handshake with the item word.
// Depends on rlsd_pkg.
interface rlsd_in_if
    import rlsd_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [SAMPLE_W-1:0] sample;
    logic                fill_on;

    modport source (output valid, output func, output sample, output fill_on, input ready);
    modport sink   (input valid, input func, input sample, input fill_on, output ready);
endinterface

FILE: sv/rlsd_out_if.sv
`timescale 1ns / 1ps
// Output channel interface: valid/ready handshake with the result word.
// Depends on rlsd_pkg.
interface rlsd_out_if
    import rlsd_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                led_on;
    logic                adc_start;
    logic                valve_pullup;
    logic                water_present;
    logic                change_event;
    logic [SAMPLE_W-1:0] signal_quality;

    modport source (output valid, output led_on, output adc_start, output valve_pullup,
                    output water_present, output change_event, output signal_quality,
                    input ready);
    modport sink   (input valid, input led_on, input adc_start, input valve_pullup,
                    input water_present, input change_event, input signal_quality,
                    output ready);
endinterface

FILE: sv/rlsd_seq.sv
`timescale 1ns / 1ps
// Measurement sequencer: phase, tick countdown, LED, filling flag and stored sample.
// Depends on rlsd_pkg.
module rlsd_seq
    import rlsd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_acc,
    input  t_item               i_item,
    input  logic [TICK_W-1:0]   i_settle,
    input  logic [TICK_W-1:0]   i_poll,
    output t_eval               o_eval,
    output t_seq_stat           o_stat
);

    t_phase              r_phase, n_phase;
    logic [TICK_W-1:0]   r_cd, n_cd;
    logic                r_led, n_led;
    logic                r_fill, n_fill;
    logic [SAMPLE_W-1:0] r_last, n_last;
    logic [TICK_W-1:0]   cd_dec;
    logic                start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LED_ON;
            r_cd    <= '0;
            r_led   <= 1'b0;
            r_fill  <= 1'b0;
            r_last  <= '0;
        end else if (i_acc) begin
            r_phase <= n_phase;
            r_cd    <= n_cd;
            r_led   <= n_led;
            r_fill  <= n_fill;
            r_last  <= n_last;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_cd    = r_cd;
        n_led   = r_led;
        n_fill  = r_fill;
        n_last  = r_last;
        start   = 1'b0;
        o_eval  = '0;
        cd_dec  = (r_cd != '0) ? r_cd - 1'b1 : r_cd;
        unique case (i_item.func)
            FUNC_TICK: begin
                n_cd = cd_dec;
                unique case (r_phase)
                    PH_SETTLE: begin
                        if (cd_dec == '0) begin
                            start   = 1'b1;
                            n_phase = PH_WAIT;
                        end
                    end
                    PH_WAIT: begin
                    end
                    default: begin
                        // unused phase code behaves as LED switch-on
                        n_phase = PH_LED_ON;
                        if (cd_dec == '0) begin
                            n_led   = 1'b1;
                            n_cd    = i_settle;
                            n_phase = PH_SETTLE;
                        end
                    end
                endcase
            end
            FUNC_CONV: begin
                if (r_phase == PH_WAIT) begin
                    n_last        = i_item.sample;
                    n_cd          = i_poll;
                    n_phase       = PH_LED_ON;
                    o_eval.valid  = 1'b1;
                    o_eval.sample = i_item.sample;
                    if (!r_fill) begin
                        n_led = 1'b0;
                    end
                end
            end
            FUNC_FILL: begin
                n_fill = i_item.fill_on;
            end
            default: begin
            end
        endcase
        o_stat.led_on         = n_led;
        o_stat.adc_start      = start;
        o_stat.valve_pullup   = n_fill;
        o_stat.signal_quality = n_last;
    end

    // LED stays on from switch-on until the sample is taken
    a_led_during_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SETTLE || r_phase == PH_WAIT) |-> r_led)
        else $error("LED off during settle or conversion wait");

    a_start_enters_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && start) |=> (r_phase == PH_WAIT && r_cd == $past(cd_dec)))
        else $error("conversion start did not enter wait phase");

endmodule

FILE: sv/rlsd_deb.sv
`timescale 1ns / 1ps
// Integrating debounce: saturating counter and detection flag updated per evaluated sample.
// Depends on rlsd_pkg.
module rlsd_deb
    import rlsd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_acc,
    input  t_eval               i_eval,
    input  logic [SAMPLE_W-1:0] i_trip,
    input  logic [DEB_W-1:0]    i_max,
    output t_deb_stat           o_stat
);

    logic [DEB_W-1:0] r_cnt, n_cnt;
    logic             r_det, n_det;
    logic [DEB_W-1:0] cnt_dn, cnt_up;
    logic             chg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_det <= 1'b0;
        end else if (i_acc) begin
            r_cnt <= n_cnt;
            r_det <= n_det;
        end
    end

    always_comb begin
        n_cnt  = r_cnt;
        n_det  = r_det;
        chg    = 1'b0;
        cnt_dn = r_cnt - 1'b1;
        cnt_up = r_cnt + 1'b1;
        if (i_eval.valid) begin
            if (i_eval.sample < i_trip) begin
                if (r_cnt != '0) begin
                    n_cnt = cnt_dn;
                    if (cnt_dn == '0 && r_det) begin
                        n_det = 1'b0;
                        chg   = 1'b1;
                    end
                end
            end else if (r_cnt < i_max) begin
                n_cnt = cnt_up;
                if (cnt_up >= i_max && !r_det) begin
                    n_det = 1'b1;
                    chg   = 1'b1;
                end
            end
        end
        o_stat.water_present = n_det;
        o_stat.change_event  = chg;
    end

    a_det_needs_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_det |-> (r_cnt != '0))
        else $error("water detected with empty debounce counter");

    a_det_changes_on_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_det != $past(r_det)) |-> $past(i_acc && i_eval.valid))
        else $error("detection flag changed without a sample");

endmodule

FILE: sv/reflective_level_sensor_debounce.sv
`timescale 1ns / 1ps
// Top level of the reflective level sensor debounce block: config registers, result register.
// Depends on rlsd_pkg, rlsd_in_if, rlsd_out_if, rlsd_seq, rlsd_deb.
//
//  channel   dir  handshake            word
//  i_in      in   valid/ready          func, sample, fill_on
//  o_out     out  valid/ready          led_on, adc_start, valve_pullup,
//                                      water_present, change_event, signal_quality
//  i_cfg_*   in   write enable only    index, data
//
// One word per cycle while o_out is not stalled: state updates at acceptance, and the result
// sits in one output register; o_out.valid rises in the cycle after acceptance.
// i_in.ready is high while the output register is empty or being drained this cycle.
// Synchronous active-low reset restores state and config register defaults; the result word is not reset.
module reflective_level_sensor_debounce
    import rlsd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rlsd_in_if.sink               i_in,
    rlsd_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [TICK_W-1:0]   r_settle;
    logic [TICK_W-1:0]   r_poll;
    logic [SAMPLE_W-1:0] r_trip;
    logic [DEB_W-1:0]    r_max;
    logic                r_out_valid;
    t_result             r_res, n_res;
    logic                acc;
    t_item               item;
    t_eval               eval;
    t_seq_stat           seq_stat;
    t_deb_stat           deb_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= SETTLE_RST;
            r_poll   <= POLL_RST;
            r_trip   <= TRIP_RST;
            r_max    <= DEB_MAX_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SETTLE:  r_settle <= i_cfg_data;
                CFG_POLL:    r_poll   <= i_cfg_data;
                CFG_TRIP:    r_trip   <= i_cfg_data[SAMPLE_W-1:0];
                CFG_DEB_MAX: r_max    <= i_cfg_data[DEB_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign i_in.ready   = !r_out_valid || o_out.ready;
    assign acc          = i_in.valid && i_in.ready;
    assign item.func    = i_in.func;
    assign item.sample  = i_in.sample;
    assign item.fill_on = i_in.fill_on;

    rlsd_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_acc    (acc),
        .i_item   (item),
        .i_settle (r_settle),
        .i_poll   (r_poll),
        .o_eval   (eval),
        .o_stat   (seq_stat)
    );

    rlsd_deb u_deb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_eval  (eval),
        .i_trip  (r_trip),
        .i_max   (r_max),
        .o_stat  (deb_stat)
    );

    always_comb begin
        n_res.led_on         = seq_stat.led_on;
        n_res.adc_start      = seq_stat.adc_start;
        n_res.valve_pullup   = seq_stat.valve_pullup;
        n_res.water_present  = deb_stat.water_present;
        n_res.change_event   = deb_stat.change_event;
        n_res.signal_quality = seq_stat.signal_quality;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (acc) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.led_on         = r_res.led_on;
    assign o_out.adc_start      = r_res.adc_start;
    assign o_out.valve_pullup   = r_res.valve_pullup;
    assign o_out.water_present  = r_res.water_present;
    assign o_out.change_event   = r_res.change_event;
    assign o_out.signal_quality = r_res.signal_quality;

    // conversion is only requested with the LED lit
    a_start_with_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.adc_start) |-> r_res.led_on)
        else $error("conversion start with LED off");

    a_no_accept_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !acc)
        else $error("word accepted over a pending result");

endmodule
